// ----- design/gradient_magnitude_top_defines.svh -----
// ---------------------------------------------------------------------------
// Gradient magnitude assertion macros
// Shared assertion wrappers, clocked on clk_i; GM_ASSERT is disabled by rst_ni.
// ---------------------------------------------------------------------------
`ifndef GRADIENT_MAGNITUDE_TOP_DEFINES_SVH
`define GRADIENT_MAGNITUDE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only outside of reset.
`define GM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define GM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GM_ASSERT(lbl, prop, msg)
`define GM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- design/gm_pkg.sv -----
// ---------------------------------------------------------------------------
// Gradient magnitude package
// Widths, the square root beat type and the per-stage root step.
// ---------------------------------------------------------------------------
package gm_pkg;

  localparam int unsigned RadW          = 32;  // sum of squares, up to 2^31
  localparam int unsigned RootW         = 16;  // floor root, up to 46340
  localparam int unsigned RemW          = 18;  // remainder stays below 2*root+1
  localparam int unsigned AbsW          = 17;  // |x| up to 32768
  localparam int unsigned SqW           = 31;  // |x|^2 up to 2^30
  localparam int unsigned MagW          = 15;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned SqrtStages    = RootW / StepsPerStage;

  localparam logic [MagW-1:0] MagMax = {MagW{1'b1}};

  typedef struct packed {
    logic [RadW-1:0]  rad;   // radicand bits still to be consumed, MSBs first
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic             last;
  } sqrt_beat_t;

  // Two result bits per call of the digit-by-digit square root.
  function automatic sqrt_beat_t sqrt_step(sqrt_beat_t b);
    sqrt_beat_t       r;
    logic [RemW+1:0]  rem_w;
    logic [RemW+1:0]  trial;
    r = b;
    for (int k = 0; k < StepsPerStage; k++) begin
      rem_w = {r.rem, r.rad[RadW-1 -: 2]};
      trial = {2'b00, r.root, 2'b01};
      r.rad = {r.rad[RadW-3:0], 2'b00};
      if (rem_w >= trial) begin
        r.rem  = RemW'(rem_w - trial);
        r.root = {r.root[RootW-2:0], 1'b1};
      end else begin
        r.rem  = rem_w[RemW-1:0];
        r.root = {r.root[RootW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ----- design/gm_square.sv -----
// ---------------------------------------------------------------------------
// Gradient magnitude front end
// Three stages: absolute values, squares, and the sum of squares.
// ---------------------------------------------------------------------------
module gm_square (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [15:0]        grad_x_i,
  input  logic [15:0]        grad_y_i,
  input  logic               last_i,
  output logic               valid_o,
  input  logic               ready_i,
  output gm_pkg::sqrt_beat_t beat_o
);
  import gm_pkg::*;

  logic            abs_valid_q, sq_valid_q, sum_valid_q;
  logic            abs_ready, sq_ready, sum_ready;
  logic [AbsW-1:0] ax_d, ay_d, ax_q, ay_q;
  logic            abs_last_q, sq_last_q;
  logic [2*AbsW-1:0] prod_x, prod_y;
  logic [SqW-1:0]  sqx_q, sqy_q;
  sqrt_beat_t      sum_d, sum_q;

  // A stage takes a new beat when it is empty or its content moves on.
  assign sum_ready = !sum_valid_q || ready_i;
  assign sq_ready  = !sq_valid_q  || sum_ready;
  assign abs_ready = !abs_valid_q || sq_ready;
  assign ready_o   = abs_ready;

  // Sign extend, then negate; -32768 yields 32768 in 17 bits.
  assign ax_d = grad_x_i[15] ? (AbsW'(0) - {1'b1, grad_x_i}) : {1'b0, grad_x_i};
  assign ay_d = grad_y_i[15] ? (AbsW'(0) - {1'b1, grad_y_i}) : {1'b0, grad_y_i};

  assign prod_x = ax_q * ax_q;
  assign prod_y = ay_q * ay_q;

  always_comb begin
    sum_d      = '0;
    sum_d.rad  = {1'b0, sqx_q} + {1'b0, sqy_q};
    sum_d.last = sq_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_valid_q <= 1'b0;
      sq_valid_q  <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      if (abs_ready) abs_valid_q <= valid_i;
      if (sq_ready)  sq_valid_q  <= abs_valid_q;
      if (sum_ready) sum_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (abs_ready && valid_i) begin
      ax_q       <= ax_d;
      ay_q       <= ay_d;
      abs_last_q <= last_i;
    end
    if (sq_ready && abs_valid_q) begin
      sqx_q     <= prod_x[SqW-1:0];
      sqy_q     <= prod_y[SqW-1:0];
      sq_last_q <= abs_last_q;
    end
    if (sum_ready && sq_valid_q) begin
      sum_q <= sum_d;
    end
  end

  assign valid_o = sum_valid_q;
  assign beat_o  = sum_q;

endmodule

// ----- design/gm_sqrt_stage.sv -----
// ---------------------------------------------------------------------------
// Gradient magnitude root stage
// One register stage of the digit-by-digit square root, two bits per stage.
// ---------------------------------------------------------------------------
module gm_sqrt_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  gm_pkg::sqrt_beat_t beat_i,
  output logic               valid_o,
  input  logic               ready_i,
  output gm_pkg::sqrt_beat_t beat_o
);
  import gm_pkg::*;

  logic       valid_q;
  sqrt_beat_t beat_d, beat_q;

  assign ready_o = !valid_q || ready_i;
  assign beat_d  = sqrt_step(beat_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ----- design/gradient_magnitude_top.sv -----
// ---------------------------------------------------------------------------
// Gradient magnitude
// floor(sqrt(x*x + y*y)) of a signed 16-bit pair, saturated to 15 bits.
// ---------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o   grad_x_i, grad_y_i, last_in_i
// out      output     out_valid_o/out_ready_i magnitude_o, last_out_o
//
// One beat enters per cycle unless the output stalls; each beat passes three
// front-end stages (absolute value, square, sum), eight root stages of two bits
// each, and the output register. Every stage holds its beat while the next
// one is full, so a stall at the output backs up stage by stage without loss
// or repeats. Reset clears only the valid bits.
// ---------------------------------------------------------------------------
`include "gradient_magnitude_top_defines.svh"

module gradient_magnitude_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] grad_x_i,
  input  logic [15:0] grad_y_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [14:0] magnitude_o,
  output logic        last_out_o
);
  import gm_pkg::*;

  logic [SqrtStages:0] st_valid;
  logic [SqrtStages:0] st_ready;
  sqrt_beat_t          st_beat [SqrtStages+1];

  logic            out_valid_q;
  logic            out_ready;
  logic [MagW-1:0] mag_d, mag_q;
  logic            last_q;

  gm_square u_square (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .grad_x_i (grad_x_i),
    .grad_y_i (grad_y_i),
    .last_i   (last_in_i),
    .valid_o  (st_valid[0]),
    .ready_i  (st_ready[0]),
    .beat_o   (st_beat[0])
  );

  for (genvar s = 0; s < SqrtStages; s++) begin : g_root
    gm_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[s]),
      .ready_o (st_ready[s]),
      .beat_i  (st_beat[s]),
      .valid_o (st_valid[s+1]),
      .ready_i (st_ready[s+1]),
      .beat_o  (st_beat[s+1])
    );
  end

  assign out_ready            = !out_valid_q || out_ready_i;
  assign st_ready[SqrtStages] = out_ready;

  // Roots above the 15-bit range clip to full scale.
  assign mag_d = (st_beat[SqrtStages].root > RootW'(MagMax)) ? MagMax
               : st_beat[SqrtStages].root[MagW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= st_valid[SqrtStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && st_valid[SqrtStages]) begin
      mag_q  <= mag_d;
      last_q <= st_beat[SqrtStages].last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;
  assign last_out_o  = last_q;

  // The valid bit is cleared asynchronously when reset is asserted and stays clear while reset is held.
  `GM_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |=> !out_valid_o,
                    "result beat shown during reset")
  `GM_ASSERT(a_empty_out_takes_input, !out_valid_o |-> in_ready_o,
             "input refused with empty output stage")
  `GM_ASSERT(a_root_remainder_bound,
             st_valid[SqrtStages] |->
               ({1'b0, st_beat[SqrtStages].rem} <= {st_beat[SqrtStages].root, 1'b0}) &&
               (st_beat[SqrtStages].rem[RemW-1] == 1'b0),
             "square root remainder out of range")

endmodule
